// ===== sv/sbct_pkg.sv =====
// Shared types and constants for the swept box contact time core.
// No dependencies.
`default_nettype none
package sbct_pkg;
    localparam int CoordW = 24;
    localparam int GapW   = 25;
    localparam int TimeW  = 17;
    localparam int SqW    = 36;
    localparam int QuotW  = 18;                  // quotient bits developed (covers saturation)
    localparam int RemW   = 25;                  // remainder bits; divisor up to 2^23
    localparam logic [TimeW-1:0] TimeMax = 17'h1FFFF;
    localparam logic [TimeW-1:0] TimeOne = 17'h10000;
    localparam int NumAxes = 3;

    localparam logic [1:0] RegVelX = 2'd0;
    localparam logic [1:0] RegVelY = 2'd1;
    localparam logic [1:0] RegVelZ = 2'd2;

    // Per-axis divide state handed from cell to cell.
    typedef struct packed {
        logic [RemW-1:0]  rem;       // partial remainder
        logic [GapW-1:0]  num;       // dividend bits not yet shifted in (msb first)
        logic [CoordW-1:0] den;      // |velocity|
        logic [QuotW-1:0] quo;
        logic             force_en;  // overlap, zero velocity or saturation
        logic [TimeW-1:0] force_val;
    } t_axis;

    typedef struct packed {
        logic              vld;
        t_axis [NumAxes-1:0] ax;
    } t_cell;
endpackage
`default_nettype wire

// ===== sv/sbct_cell.sv =====
// One restoring-division cell: one quotient bit for each axis per cycle while i_adv is high.
// Depends on sbct_pkg.
`default_nettype none
module sbct_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_adv,
    input  sbct_pkg::t_cell     i_d,
    output sbct_pkg::t_cell     o_q
);
    import sbct_pkg::*;

    t_cell n_c;
    t_cell r_c;

    always_comb begin
        logic [RemW:0] sh;
        logic [RemW:0] df;
        n_c = i_d;
        for (int a = 0; a < NumAxes; a++) begin
            sh = {i_d.ax[a].rem, i_d.ax[a].num[GapW-1]};
            df = sh - {{(RemW+1-CoordW){1'b0}}, i_d.ax[a].den};
            n_c.ax[a].num = {i_d.ax[a].num[GapW-2:0], 1'b0};
            if (!df[RemW]) begin
                n_c.ax[a].rem = df[RemW-1:0];
                n_c.ax[a].quo = {i_d.ax[a].quo[QuotW-2:0], 1'b1};
            end else begin
                n_c.ax[a].rem = sh[RemW-1:0];
                n_c.ax[a].quo = {i_d.ax[a].quo[QuotW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.vld <= 1'b0;
        end else if (i_adv) begin
            r_c.vld <= n_c.vld;
        end
        if (i_adv) begin
            r_c.ax <= n_c.ax;
        end
    end

    assign o_q = r_c;
endmodule
`default_nettype wire

// ===== sv/sbct_finish.sv =====
// Saturation, reach flag and square sum after the divide chain, two stages.
// Depends on sbct_pkg.
`default_nettype none
module sbct_finish (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_adv,
    input  sbct_pkg::t_cell                i_d,
    output logic                           o_vld,
    output logic [sbct_pkg::TimeW-1:0]     o_time_x,
    output logic [sbct_pkg::TimeW-1:0]     o_time_y,
    output logic [sbct_pkg::TimeW-1:0]     o_time_z,
    output logic                           o_reachable,
    output logic [sbct_pkg::SqW-1:0]       o_time_sq_sum
);
    import sbct_pkg::*;

    logic [TimeW-1:0] n_t [NumAxes];
    logic [TimeW-1:0] r_t [NumAxes];
    logic [2*TimeW-1:0] r_sq [NumAxes];
    logic [TimeW-1:0] r_o [NumAxes];
    logic r_v1, r_v2, r_ok;
    logic [SqW-1:0] r_sum;

    always_comb begin
        for (int a = 0; a < NumAxes; a++) begin
            if (i_d.ax[a].force_en) begin
                n_t[a] = i_d.ax[a].force_val;
            end else if (i_d.ax[a].quo[QuotW-1]) begin
                n_t[a] = TimeMax;
            end else begin
                n_t[a] = i_d.ax[a].quo[TimeW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_d.vld;
            r_v2 <= r_v1;
        end
        if (i_adv) begin
            for (int a = 0; a < NumAxes; a++) begin
                r_t[a]  <= n_t[a];
                r_sq[a] <= n_t[a] * n_t[a];
                r_o[a]  <= r_t[a];
            end
            r_ok  <= (r_t[0] <= TimeOne) && (r_t[1] <= TimeOne) && (r_t[2] <= TimeOne);
            r_sum <= SqW'({2'b0, r_sq[0]}) + SqW'({2'b0, r_sq[1]}) + SqW'({2'b0, r_sq[2]});
        end
    end

    assign o_vld         = r_v2;
    assign o_time_x      = r_o[0];
    assign o_time_y      = r_o[1];
    assign o_time_z      = r_o[2];
    assign o_reachable   = r_ok;
    assign o_time_sq_sum = r_sum;
endmodule
`default_nettype wire

// ===== sv/swept_box_contact_time_core.sv =====
// Top level of the swept box contact time core.
// Depends on sbct_pkg, sbct_cell, sbct_finish.
`default_nettype none
// Each request carries a moving box and an obstacle box; the core returns per
// axis the contact time |gap|/|vel| in unsigned Q1.16 (131071 = infinite or
// saturated), a reachable flag and the sum of squared times. One request is
// accepted per cycle while o_stall is low. One setup stage (gap, overlap and
// velocity magnitude) feeds a chain of 18 divide cells, each producing one
// quotient bit on all three axes, then two finishing stages (saturate, then square-sum).
// The whole pipeline advances whenever the output holds no result or it is
// taken, so a held result stalls everything in lockstep. The user must write
// velocity registers through the plain write port while the core is idle (not enforced).
module swept_box_contact_time_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [23:0] i_mover_min_x,
    input  wire logic [23:0] i_mover_min_y,
    input  wire logic [23:0] i_mover_min_z,
    input  wire logic [23:0] i_mover_max_x,
    input  wire logic [23:0] i_mover_max_y,
    input  wire logic [23:0] i_mover_max_z,
    input  wire logic [23:0] i_obstacle_min_x,
    input  wire logic [23:0] i_obstacle_min_y,
    input  wire logic [23:0] i_obstacle_min_z,
    input  wire logic [23:0] i_obstacle_max_x,
    input  wire logic [23:0] i_obstacle_max_y,
    input  wire logic [23:0] i_obstacle_max_z,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [16:0]      o_time_x,
    output logic [16:0]      o_time_y,
    output logic [16:0]      o_time_z,
    output logic             o_reachable,
    output logic [35:0]      o_time_sq_sum
);
    import sbct_pkg::*;

    localparam int NCells = QuotW;

    logic signed [CoordW-1:0] r_vel [NumAxes];
    logic adv;
    t_cell n_s0, r_s0;
    t_cell chain [NCells+1];

    // Single pipeline enable: stall only when a result waits and is held.
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NumAxes; a++) r_vel[a] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegVelX: r_vel[0] <= i_cfg_data;
                RegVelY: r_vel[1] <= i_cfg_data;
                RegVelZ: r_vel[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Setup stage: gap magnitude, overlap test, |velocity|.
    always_comb begin
        logic signed [CoordW-1:0] mn [NumAxes];
        logic signed [CoordW-1:0] mx [NumAxes];
        logic signed [CoordW-1:0] on [NumAxes];
        logic signed [CoordW-1:0] ox [NumAxes];
        logic signed [GapW-1:0] gap;
        logic signed [GapW-1:0] vx;
        mn[0] = i_mover_min_x;    mn[1] = i_mover_min_y;    mn[2] = i_mover_min_z;
        mx[0] = i_mover_max_x;    mx[1] = i_mover_max_y;    mx[2] = i_mover_max_z;
        on[0] = i_obstacle_min_x; on[1] = i_obstacle_min_y; on[2] = i_obstacle_min_z;
        ox[0] = i_obstacle_max_x; ox[1] = i_obstacle_max_y; ox[2] = i_obstacle_max_z;
        n_s0.vld = i_valid;
        for (int a = 0; a < NumAxes; a++) begin
            if (r_vel[a] > 0) begin
                gap = GapW'(on[a]) - GapW'(mx[a]);
            end else begin
                gap = GapW'(mn[a]) - GapW'(ox[a]);
            end
            vx = GapW'(r_vel[a]);
            n_s0.ax[a].num = gap[GapW-1] ? GapW'(-gap) : gap;
            n_s0.ax[a].den = vx[GapW-1] ? CoordW'(-vx) : CoordW'(vx);
            n_s0.ax[a].rem = '0;
            n_s0.ax[a].quo = '0;
            if (mx[a] >= on[a] && mn[a] <= ox[a]) begin
                n_s0.ax[a].force_en  = 1'b1;
                n_s0.ax[a].force_val = '0;
            end else begin
                n_s0.ax[a].force_en  = (r_vel[a] == 0);
                n_s0.ax[a].force_val = TimeMax;
            end
        end
    end

    // Setup register. The dividend is |gap| << 16; a quotient of 2^17 or more
    // only means saturation, which happens exactly when |gap|>>1 >= |vel|.
    // That case is caught here and folded into the forced result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.vld <= 1'b0;
        end else if (adv) begin
            r_s0.vld <= n_s0.vld;
        end
        if (adv) begin
            for (int a = 0; a < NumAxes; a++) begin
                r_s0.ax[a].force_en  <= n_s0.ax[a].force_en ||
                    ((RemW+1)'(n_s0.ax[a].num[GapW-1:1]) >= (RemW+1)'(n_s0.ax[a].den));
                r_s0.ax[a].force_val <= n_s0.ax[a].force_en ? n_s0.ax[a].force_val : TimeMax;
                r_s0.ax[a].den <= n_s0.ax[a].den;
                r_s0.ax[a].quo <= '0;
                r_s0.ax[a].rem <= '0;
                r_s0.ax[a].num <= n_s0.ax[a].num;
            end
        end
    end

    // Divide load: the remainder starts at |gap|>>2 and the two low gap bits
    // are shifted in first, then zeros. With |gap|>>1 < |vel| the first cell
    // always gives a zero bit and the other 17 give quotient bits 16..0.
    always_comb begin
        chain[0] = r_s0;
        for (int a = 0; a < NumAxes; a++) begin
            chain[0].ax[a].rem = RemW'(r_s0.ax[a].num[GapW-1:2]);
            chain[0].ax[a].num = {r_s0.ax[a].num[1:0], {(GapW-2){1'b0}}};
        end
    end

    genvar g;
    for (g = 0; g < NCells; g++) begin : g_cell
        sbct_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (adv),
            .i_d    (chain[g]),
            .o_q    (chain[g+1])
        );
    end

    sbct_finish u_fin (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_d          (chain[NCells]),
        .o_vld        (o_valid),
        .o_time_x     (o_time_x),
        .o_time_y     (o_time_y),
        .o_time_z     (o_time_z),
        .o_reachable  (o_reachable),
        .o_time_sq_sum(o_time_sq_sum)
    );

`ifndef SYNTHESIS
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid) else $error("stall without held result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(o_time_sq_sum)) else $error("held result changed");
    a_reach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_reachable |-> o_time_x <= TimeOne && o_time_y <= TimeOne)
        else $error("reach flag inconsistent");
`endif
endmodule
`default_nettype wire

// ===== tb/sbct_checker.sv =====
// Checker for the swept box contact time core: predicts and compares results.
// Depends on sbct_pkg; watches the request and result channels of the core.
`default_nettype none
module sbct_checker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [23:0]       i_cfg_data,
    input  wire logic              i_valid,
    input  wire logic              i_stall_in,
    input  wire logic [23:0]       i_box [12],
    input  wire logic              i_res_valid,
    input  wire logic              i_res_stall,
    input  wire logic [16:0]       i_time_x,
    input  wire logic [16:0]       i_time_y,
    input  wire logic [16:0]       i_time_z,
    input  wire logic              i_reachable,
    input  wire logic [35:0]       i_time_sq_sum,
    output int                     o_fail_count,
    output int                     o_pending
);
    import sbct_pkg::*;

    typedef struct packed {
        logic [16:0] tx;
        logic [16:0] ty;
        logic [16:0] tz;
        logic        reach;
        logic [35:0] sq;
    } t_contact;

    logic signed [23:0] speed [3];
    t_contact           contact_q [$];

    function automatic logic [16:0] axis_contact(logic signed [23:0] v,
            logic signed [23:0] mmin, logic signed [23:0] mmax,
            logic signed [23:0] omin, logic signed [23:0] omax);
        logic signed [24:0] gap;
        logic [24:0]        mag_gap;
        logic [24:0]        mag_v;
        logic [41:0]        quot;
        if (mmax >= omin && mmin <= omax) return '0;
        if (v == 0) return TimeMax;
        gap = (v > 0) ? 25'(omin) - 25'(mmax) : 25'(mmin) - 25'(omax);
        mag_gap = gap[24] ? 25'(-gap) : 25'(gap);
        mag_v = v[23] ? -25'(v) : 25'(v);
        quot = {mag_gap, 16'd0} / 42'(mag_v);
        return (quot > 42'(TimeMax)) ? TimeMax : quot[16:0];
    endfunction

    function automatic t_contact predict_contact(logic [23:0] b [12]);
        t_contact r;
        r.tx = axis_contact(speed[0], b[0], b[3], b[6], b[9]);
        r.ty = axis_contact(speed[1], b[1], b[4], b[7], b[10]);
        r.tz = axis_contact(speed[2], b[2], b[5], b[8], b[11]);
        r.reach = r.tx <= TimeOne && r.ty <= TimeOne && r.tz <= TimeOne;
        r.sq = 36'(r.tx) * r.tx + 36'(r.ty) * r.ty + 36'(r.tz) * r.tz;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_contact want;
        t_contact got;
        if (!i_rst_n) begin
            speed[0] <= '0;
            speed[1] <= '0;
            speed[2] <= '0;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    RegVelX: speed[0] <= i_cfg_data;
                    RegVelY: speed[1] <= i_cfg_data;
                    RegVelZ: speed[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !i_stall_in) contact_q.push_back(predict_contact(i_box));
            if (i_res_valid && !i_res_stall) begin
                got = '{i_time_x, i_time_y, i_time_z, i_reachable, i_time_sq_sum};
                if (contact_q.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result %p", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = contact_q.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p got %p", want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= contact_q.size();
    end
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench top for the swept box contact time core: stimulus and verdict.
// Depends on sbct_pkg, swept_box_contact_time_core and sbct_checker.
`default_nettype none
module tb;
    import sbct_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = RegVelX;
    logic [23:0] cfg_data = '0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [23:0] box [12];
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [16:0] time_x, time_y, time_z;
    logic        reachable;
    logic [35:0] time_sq_sum;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    int          send_idle_pct = 0;   // chance per cycle that the sender holds off
    int          recv_stall_pct = 0;  // chance per cycle that the receiver stalls

    localparam int Latency = 21;
    localparam int WatchdogLimit = 4000;

    initial for (int i = 0; i < 12; i++) box[i] = '0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    swept_box_contact_time_core DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(req_valid), .o_stall(req_stall),
        .i_mover_min_x(box[0]), .i_mover_min_y(box[1]), .i_mover_min_z(box[2]),
        .i_mover_max_x(box[3]), .i_mover_max_y(box[4]), .i_mover_max_z(box[5]),
        .i_obstacle_min_x(box[6]), .i_obstacle_min_y(box[7]),
        .i_obstacle_min_z(box[8]), .i_obstacle_max_x(box[9]),
        .i_obstacle_max_y(box[10]), .i_obstacle_max_z(box[11]),
        .o_valid(res_valid), .i_stall(res_stall),
        .o_time_x(time_x), .o_time_y(time_y), .o_time_z(time_z),
        .o_reachable(reachable), .o_time_sq_sum(time_sq_sum)
    );

    sbct_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(req_valid), .i_stall_in(req_stall), .i_box(box),
        .i_res_valid(res_valid), .i_res_stall(res_stall),
        .i_time_x(time_x), .i_time_y(time_y), .i_time_z(time_z),
        .i_reachable(reachable), .i_time_sq_sum(time_sq_sum),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver stalls at random, changed on the falling edge.
    always @(negedge clk) res_stall <= ($urandom_range(99) < recv_stall_pct);

    // Watchdog: cycles with no handshake on either channel.
    always @(posedge clk) begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Coordinate picker: extremes, near-zero, small cluster, or full range.
    function automatic logic [23:0] pick_coord();
        case ($urandom_range(9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($signed($urandom_range(8)) - 4);
            3, 4, 5, 6: return 24'($signed($urandom_range(4096)) - 2048);
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [23:0] pick_speed();
        case ($urandom_range(7))
            0: return '0;
            1: return 24'h7FFFFF;
            2: return 24'h800000;
            3: return 24'($signed($urandom_range(4)) - 2);
            4, 5: return 24'($signed($urandom_range(2048)) - 1024);
            default: return 24'($urandom());
        endcase
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_speed(input logic [23:0] vx, vy, vz);
        write_reg(RegVelX, vx);
        write_reg(RegVelY, vy);
        write_reg(RegVelZ, vz);
    endtask

    // Present one request, holding it until accepted; optional idle gap first.
    task automatic send_request(input logic [23:0] b [12]);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        for (int i = 0; i < 12; i++) box[i] <= b[i];
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (Latency + 4) @(negedge clk);
    endtask

    // Request per axis: ordered bounds with the obstacle offset by a random distance, or noise.
    task automatic random_request();
        logic [23:0] b [12];
        logic signed [23:0] lo, hi, t;
        for (int a = 0; a < 3; a++) begin
            if ($urandom_range(9) < 7) begin
                lo = pick_coord();
                hi = lo + 24'($urandom_range(512));
                b[a] = lo;
                b[a + 3] = hi;
                t = hi + 24'($signed($urandom_range(4096)) - 1024);
                b[a + 6] = t;
                b[a + 9] = t + 24'($urandom_range(512));
            end else begin
                // noise, inverted bounds included
                for (int k = 0; k < 4; k++) b[a + 3 * k] = pick_coord();
            end
        end
        send_request(b);
    endtask

    initial begin
        logic [23:0] d [12];
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: zero velocity, overlap, extremes, behind the mover, saturation.
        for (int i = 0; i < 12; i++) d[i] = '0;
        send_request(d);                                    // overlap on all axes
        d[9] = 24'h000100; d[6] = 24'h000200; d[3] = 24'h000100;
        send_request(d);                                    // zero vel, apart on x
        drain();
        set_speed(24'h000100, 24'hFFFF00, 24'h7FFFFF);
        for (int i = 0; i < 12; i++) d[i] = '0;
        d[3] = 24'h000100; d[6] = 24'h000180; d[9] = 24'h000300;  // x ahead, half step
        d[1] = 24'h000500; d[4] = 24'h000600; d[10] = 24'h000100; // y ahead (neg vel)
        d[5] = 24'h800000; d[8] = 24'h7FFFFF; d[11] = 24'h7FFFFF; d[2] = 24'h800000;
        send_request(d);
        d[6] = 24'h800000; d[9] = 24'h800000;              // x behind the mover
        d[3] = 24'h7FFFFF; d[0] = 24'h7FFFFF;
        send_request(d);
        d[6] = 24'h7FFFFF; d[9] = 24'h7FFFFF; d[3] = 24'h800000; d[0] = 24'h800000;
        send_request(d);                                   // huge gap, saturates
        d[0] = 24'h000200; d[3] = 24'h000100;               // inverted bounds
        send_request(d);
        drain();
        set_speed(24'h800000, 24'h000001, 24'hFFFFFF);
        send_request(d);
        d[6] = 24'h000101; d[9] = 24'h000101; d[3] = 24'h000100; d[0] = 24'h000000;
        d[7] = 24'h000002; d[10] = 24'h000002; d[1] = 24'h000000; d[4] = 24'h000001;
        send_request(d);                                   // one-step time on y, saturated time on x
        drain();

        // Random phases with different handshake pressure and speed settings.
        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 5)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                3: begin send_idle_pct = 27; recv_stall_pct = 27; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            if (ph == 9) set_speed(24'h7FFFFF, 24'h800000, 24'h000000);
            else set_speed(pick_speed(), pick_speed(), pick_speed());
            repeat (175) random_request();
            drain();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
